>>> hdl/spi_rfs_pkg.sv
// Shared types and constants for the SPI register-frame slave.
package spi_rfs_pkg;

  localparam int REG_COUNT_DEF = 16;   // implemented registers
  localparam int ADDR_W        = 7;    // command address field
  localparam int DATA_W        = 32;   // register width
  localparam int POS_W         = 3;

  // Command byte layout
  localparam int CMD_READ_BIT  = 7;

  // Frame position codes
  localparam logic [POS_W-1:0] POS_IDLE  = 3'd0;
  localparam logic [POS_W-1:0] POS_SLOT1 = 3'd1;
  localparam logic [POS_W-1:0] POS_SLOT4 = 3'd4;
  localparam logic [POS_W-1:0] POS_DONE  = 3'd5;

  // Data slot within a frame, MSB slot first
  localparam logic [1:0] SLOT_B3 = 2'd0;
  localparam logic [1:0] SLOT_B2 = 2'd1;
  localparam logic [1:0] SLOT_B1 = 2'd2;
  localparam logic [1:0] SLOT_B0 = 2'd3;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] mosi_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] miso_byte;
    logic       write_strobe;
  } out_t;

  // Per-request record passed from frame control to the output stage
  typedef struct packed {
    logic       rd_slot;   // request is a data slot of a read frame
    logic [1:0] slot;      // which data byte
    logic       hit;       // register in range and written since reset
    logic       strobe;    // request committed a write
  } rec_t;

endpackage

>>> hdl/spi_rfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module spi_rfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/spi_rfs_frame.sv
// Frame decoder: byte position tracking, write assembly and request record stage.
module spi_rfs_frame #(
  parameter int REG_COUNT = spi_rfs_pkg::REG_COUNT_DEF,
  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  spi_rfs_pkg::in_t                 in_data,
  input  logic                             s2_ready,
  output logic                             s1_valid,
  output spi_rfs_pkg::rec_t                s1_rec,
  output logic                             ram_we,
  output logic [AW-1:0]                    ram_waddr,
  output logic [spi_rfs_pkg::DATA_W-1:0]   ram_wdata,
  output logic                             ram_re,
  output logic [AW-1:0]                    ram_raddr
);
  import spi_rfs_pkg::*;

  localparam logic [ADDR_W:0] REG_LIMIT = (ADDR_W+1)'(REG_COUNT);

  logic [POS_W-1:0]  byte_pos_r, byte_pos_nxt;
  logic              read_flag_r, read_flag_nxt;
  logic [ADDR_W-1:0] frame_addr_r, frame_addr_nxt;
  logic [23:0]       incoming_r, incoming_nxt;
  logic [REG_COUNT-1:0] wr_valid_r;
  logic              s1_valid_r;
  rec_t              s1_rec_r, rec_nxt;
  logic              s1_ready;
  logic              in_accept;
  logic              in_range;
  logic [AW-1:0]     addr_idx;
  logic              data_slot;

  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign in_accept = in_valid && s1_ready;

  assign in_range  = {1'b0, frame_addr_r} < REG_LIMIT;
  assign addr_idx  = frame_addr_r[AW-1:0];
  assign data_slot = (byte_pos_r >= POS_SLOT1) && (byte_pos_r <= POS_SLOT4);

  assign ram_waddr = addr_idx;
  assign ram_wdata = {incoming_r, in_data.mosi_byte};
  assign ram_raddr = addr_idx;
  assign ram_re    = s1_ready;

  always_comb begin
    byte_pos_nxt   = byte_pos_r;
    read_flag_nxt  = read_flag_r;
    frame_addr_nxt = frame_addr_r;
    incoming_nxt   = incoming_r;
    rec_nxt        = '0;
    ram_we         = 1'b0;
    if (in_accept) begin
      if (in_data.frame_start) begin
        // command byte opens a new frame, drops any partial write
        read_flag_nxt  = in_data.mosi_byte[CMD_READ_BIT];
        frame_addr_nxt = in_data.mosi_byte[ADDR_W-1:0];
        incoming_nxt   = '0;
        byte_pos_nxt   = POS_SLOT1;
      end else if (data_slot) begin
        if (read_flag_r) begin
          rec_nxt.rd_slot = 1'b1;
          rec_nxt.slot    = 2'(byte_pos_r - POS_SLOT1);
          rec_nxt.hit     = in_range && wr_valid_r[addr_idx];
        end else if (byte_pos_r != POS_SLOT4) begin
          incoming_nxt = {incoming_r[15:0], in_data.mosi_byte};
        end else if (in_range) begin
          ram_we         = 1'b1;
          rec_nxt.strobe = 1'b1;
        end
        byte_pos_nxt = byte_pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r   <= POS_IDLE;
      read_flag_r  <= 1'b0;
      frame_addr_r <= '0;
      incoming_r   <= '0;
      wr_valid_r   <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      byte_pos_r   <= byte_pos_nxt;
      read_flag_r  <= read_flag_nxt;
      frame_addr_r <= frame_addr_nxt;
      incoming_r   <= incoming_nxt;
      if (ram_we) begin
        wr_valid_r[addr_idx] <= 1'b1;
      end
      if (s1_ready) begin
        s1_valid_r <= in_accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_rec_r <= rec_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_rec   = s1_rec_r;

`ifndef NO_ASSERTIONS
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= POS_DONE)
    else $error("frame position out of range");

  a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.frame_start |=> byte_pos_r == POS_SLOT1)
    else $error("command byte did not open a frame");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> in_range && !read_flag_r && byte_pos_r == POS_SLOT4)
    else $error("register write outside a write frame's last slot");

  a_rec_excl: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> !(s1_rec_r.strobe && s1_rec_r.rd_slot))
    else $error("request marked as both read slot and write commit");
`endif

endmodule

>>> hdl/spi_rfs_out.sv
// Output stage: selects the read byte and holds the result register.
module spi_rfs_out (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s1_valid,
  input  spi_rfs_pkg::rec_t              s1_rec,
  input  logic [spi_rfs_pkg::DATA_W-1:0] rd_data,
  output logic                           s2_ready,
  output logic                           out_valid,
  input  logic                           out_stall,
  output spi_rfs_pkg::out_t              out_data
);
  import spi_rfs_pkg::*;

  logic              out_valid_r;
  out_t              out_data_r, out_data_nxt;
  logic [DATA_W-1:0] word;
  logic [7:0]        sel_byte;

  assign s2_ready = !out_valid_r || !out_stall;
  assign word     = s1_rec.hit ? rd_data : '0;

  always_comb begin
    case (s1_rec.slot)
      SLOT_B3: sel_byte = word[31:24];
      SLOT_B2: sel_byte = word[23:16];
      SLOT_B1: sel_byte = word[15:8];
      SLOT_B0: sel_byte = word[7:0];
      default: sel_byte = '0;
    endcase
    out_data_nxt.miso_byte    = s1_rec.rd_slot ? sel_byte : 8'h00;
    out_data_nxt.write_strobe = s1_rec.strobe;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/spi_register_frame_slave_top.sv
// Top level of the SPI register-frame slave.
//
// Device side of a byte-framed register link. Each input request is one
// full-duplex byte exchange; frame_start marks the command byte (bit 7 = read,
// bits 6..0 = address). The next four bytes are the 32-bit data, MSB first.
// Reads return the register bytes in the four data slots; writes commit the
// word on the fourth data byte and pulse write_strobe with that byte's result.
// Addresses at or above REG_COUNT read zero and ignore writes. Bytes outside
// a frame, after the fourth data byte, and in write data slots return zero.
// Rate: one byte per clock while out_stall is low. Accepted bytes reach
// out_valid via a request stage where frame control runs and the register
// RAM is read, then the result register where the read byte is selected.
// The register file is a RAM of REG_COUNT x 32 bits with one write and one
// registered read port; per-register written flags give the all-zero reset
// state without a clearing pass, so the block takes bytes right after reset.
// in_stall rises only when both stages hold results and out_stall is high.
module spi_register_frame_slave_top #(
  parameter int REG_COUNT = spi_rfs_pkg::REG_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spi_rfs_pkg::in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spi_rfs_pkg::out_t out_data
);
  import spi_rfs_pkg::*;

  localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  // stage handoff
  logic              s1_valid;
  rec_t              s1_rec;
  logic              s2_ready;

  // register RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // frame control and request stage
  spi_rfs_frame #(
    .REG_COUNT (REG_COUNT)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .s2_ready  (s2_ready),
    .s1_valid  (s1_valid),
    .s1_rec    (s1_rec),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  // register store; read data lines up with the request stage
  spi_rfs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REG_COUNT)
  ) u_regs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // byte select and result register
  spi_rfs_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_rec    (s1_rec),
    .rd_data   (ram_rdata),
    .s2_ready  (s2_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
